// ===== hw/rtl/tgap_pkg.sv =====
// Shared types and constants for the TGA pixel to RGBA8888 converter.
// Used by tgap_fetch, tgap_convert and tga_pixel_to_rgba_unit; no dependencies.
package tgap_pkg;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic [31:0] data_word;
    logic        last_pixel;
  } tgap_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] mask_alpha;
    logic [1:0] status;
    logic       end_of_image;
  } tgap_out_t;

  // Pixel held between the fetch stage and the converter
  typedef struct packed {
    logic [31:0] word;     // pixel bytes, offset already applied
    logic        last;
    logic        oob;      // palette index at or past PALETTE_ENTRIES
  } tgap_stage_t;

  // Configuration held by the top level
  typedef struct packed {
    logic [7:0] image_type;
    logic [1:0] pixel_depth;
    logic [1:0] palette_depth;
    logic [7:0] index_offset;
  } tgap_cfg_t;

  localparam logic [1:0] CFG_IMAGE_TYPE    = 2'd0;
  localparam logic [1:0] CFG_PIXEL_DEPTH   = 2'd1;
  localparam logic [1:0] CFG_PALETTE_DEPTH = 2'd2;
  localparam logic [1:0] CFG_INDEX_OFFSET  = 2'd3;

  localparam logic OP_CONVERT   = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic [1:0] PDEPTH_15 = 2'd0;
  localparam logic [1:0] PDEPTH_16 = 2'd1;
  localparam logic [1:0] PDEPTH_24 = 2'd2;
  localparam logic [1:0] PDEPTH_32 = 2'd3;

  localparam logic [7:0] TYPE_PAL      = 8'd1;
  localparam logic [7:0] TYPE_TRUE     = 8'd2;
  localparam logic [7:0] TYPE_GRAY     = 8'd3;
  localparam logic [7:0] TYPE_PAL_RLE  = 8'd9;
  localparam logic [7:0] TYPE_TRUE_RLE = 8'd10;
  localparam logic [7:0] TYPE_GRAY_RLE = 8'd11;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DEPTH = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [4:0]  FIELD_MASK5  = 5'h1F;
  localparam logic [15:0] PAL_ALPHA_BIT = 16'h8000;

endpackage

// ===== hw/rtl/tga_pixel_to_rgba_unit.sv =====
// Top level of the TGA pixel to RGBA8888 converter: configuration registers,
// fetch stage with palette memory, and conversion stage. Depends on tgap_pkg,
// tgap_fetch and tgap_convert.
//
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i): one beat per pixel or per
//   palette write. A pixel beat gives one out beat; a palette write gives none.
//   out channel (out_valid_o/out_ready_i/out_data_o): converted pixels in order.
//   cfg port (cfg_we_i/cfg_idx_i/cfg_wdata_i): write registers only while idle.
// Path: an accepted pixel passes the pixel stage register, then the output register.
// Throughput: one beat per cycle while out_ready_i is high; the palette memory
//   reads every cycle and can take a write in the same cycle, and the pixel
//   stage holds one beat between the memory read and the output register.
// Reset: registers return to image type 2, 24-bit pixels, 24-bit palette,
//   offset 0; both stages empty. The palette memory is not cleared; load an
//   entry before any pixel points at it.
// Stall: when out_ready_i is low the output register and the pixel stage fill,
//   then in_ready_o drops; the held pixel re-reads its palette entry each cycle.
module tga_pixel_to_rgba_unit
  import tgap_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tgap_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tgap_out_t  out_data_o
);

  tgap_cfg_t   cfg_q, cfg_d;
  logic        st_valid;
  tgap_stage_t st_data;
  logic [31:0] pal_rdata;
  logic        st_take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_TYPE:    cfg_d.image_type    = cfg_wdata_i;
        CFG_PIXEL_DEPTH:   cfg_d.pixel_depth   = cfg_wdata_i[1:0];
        CFG_PALETTE_DEPTH: cfg_d.palette_depth = cfg_wdata_i[1:0];
        CFG_INDEX_OFFSET:  cfg_d.index_offset  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_type    <= TYPE_TRUE;
      cfg_q.pixel_depth   <= DEPTH_24;
      cfg_q.palette_depth <= PDEPTH_24;
      cfg_q.index_offset  <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgap_fetch #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .st_valid_o (st_valid),
    .st_data_o  (st_data),
    .pal_rdata_o(pal_rdata),
    .st_take_i  (st_take)
  );

  tgap_convert u_convert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .st_valid_i (st_valid),
    .st_data_i  (st_data),
    .pal_rdata_i(pal_rdata),
    .st_take_o  (st_take),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/tgap_fetch.sv =====
// Input stage of the TGA converter: applies the index offset, owns the palette
// memory (a read every cycle plus any write, registered read) and holds one pixel.
// Depends on tgap_pkg.
module tgap_fetch
  import tgap_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tgap_cfg_t   cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tgap_in_t    in_data_i,
  output logic        st_valid_o,
  output tgap_stage_t st_data_o,
  output logic [31:0] pal_rdata_o,
  input  logic        st_take_i
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0] ENTRIES_9 = 9'(PALETTE_ENTRIES);

  logic [31:0] mem [PALETTE_ENTRIES];
  logic [31:0] rdata_q;

  logic        st_valid_q, st_valid_d;
  tgap_stage_t st_data_q, st_data_d;
  logic [IDX_W-1:0] st_idx_q, st_idx_d;

  logic        accept;
  logic        hold;
  logic [31:0] word_adj;
  logic        wr_in_range;
  logic        rd_in_range;
  logic [IDX_W-1:0] rd_addr;

  assign in_ready_o = !st_valid_q || st_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hold       = st_valid_q && !st_take_i;

  always_comb begin
    word_adj = in_data_i.data_word;
    if (cfg_i.pixel_depth == DEPTH_8) begin
      word_adj[7:0] = in_data_i.data_word[7:0] + cfg_i.index_offset;
    end
  end

  assign wr_in_range = {1'b0, in_data_i.entry_index} < ENTRIES_9;
  assign rd_in_range = {1'b0, word_adj[7:0]} < ENTRIES_9;

  // Re-read the held pixel's entry while the converter is stalled
  assign rd_addr = hold ? st_idx_q : word_adj[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.opcode == OP_PAL_WRITE && wr_in_range) begin
      mem[in_data_i.entry_index[IDX_W-1:0]] <= in_data_i.data_word;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    st_valid_d = st_valid_q;
    st_data_d  = st_data_q;
    st_idx_d   = st_idx_q;
    if (st_take_i) begin
      st_valid_d = 1'b0;
    end
    if (accept && in_data_i.opcode == OP_CONVERT) begin
      st_valid_d     = 1'b1;
      st_data_d.word = word_adj;
      st_data_d.last = in_data_i.last_pixel;
      st_data_d.oob  = !rd_in_range;
      st_idx_d       = word_adj[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_data_q <= st_data_d;
    st_idx_q  <= st_idx_d;
  end

  assign st_valid_o  = st_valid_q;
  assign st_data_o   = st_data_q;
  assign pal_rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tgap_convert.sv =====
// Color conversion stage: turns a held pixel and its palette entry into an
// RGBA8888 beat and keeps it in the output register. Depends on tgap_pkg.
module tgap_convert
  import tgap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tgap_cfg_t   cfg_i,
  input  logic        st_valid_i,
  input  tgap_stage_t st_data_i,
  input  logic [31:0] pal_rdata_i,
  output logic        st_take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tgap_out_t   out_data_o
);

  logic      out_valid_q, out_valid_d;
  tgap_out_t out_data_q, out_data_d;
  tgap_out_t res;
  logic [31:0] w;
  logic [31:0] pe;

  assign st_take_o = st_valid_i && (!out_valid_q || out_ready_i);
  assign w  = st_data_i.word;
  assign pe = st_data_i.oob ? 32'd0 : pal_rdata_i;

  always_comb begin
    res = '0;
    res.end_of_image = st_data_i.last;
    unique case (cfg_i.image_type) inside
      TYPE_GRAY, TYPE_GRAY_RLE: begin
        if (cfg_i.pixel_depth == DEPTH_8 || cfg_i.pixel_depth == DEPTH_16) begin
          res.red   = w[7:0];
          res.green = w[7:0];
          res.blue  = w[7:0];
          res.alpha = (cfg_i.pixel_depth == DEPTH_16) ? w[15:8] : ALPHA_OPAQUE;
          res.mask_alpha = res.alpha;
        end else begin
          res.status = ST_BAD_DEPTH;
        end
      end
      TYPE_TRUE, TYPE_TRUE_RLE: begin
        if (cfg_i.pixel_depth == DEPTH_16) begin
          res.red   = {w[14:10] & FIELD_MASK5, 3'b000};
          res.green = {w[9:5] & FIELD_MASK5, 3'b000};
          res.blue  = {w[4:0] & FIELD_MASK5, 3'b000};
          res.alpha = ALPHA_OPAQUE;
          res.mask_alpha = ALPHA_OPAQUE;
        end else if (cfg_i.pixel_depth == DEPTH_24 || cfg_i.pixel_depth == DEPTH_32) begin
          res.red   = w[23:16];
          res.green = w[15:8];
          res.blue  = w[7:0];
          res.alpha = (cfg_i.pixel_depth == DEPTH_32) ? w[31:24] : ALPHA_OPAQUE;
          res.mask_alpha = res.alpha;
        end else begin
          res.status = ST_BAD_DEPTH;
        end
      end
      TYPE_PAL, TYPE_PAL_RLE: begin
        if (cfg_i.pixel_depth == DEPTH_8) begin
          res.mask_alpha = ALPHA_OPAQUE;
          if (cfg_i.palette_depth == PDEPTH_24 || cfg_i.palette_depth == PDEPTH_32) begin
            res.red   = pe[23:16];
            res.green = pe[15:8];
            res.blue  = pe[7:0];
            res.alpha = (cfg_i.palette_depth == PDEPTH_32) ? pe[31:24] : ALPHA_OPAQUE;
          end else begin
            res.red   = {pe[14:10], 3'b000};
            res.green = {pe[9:5], 3'b000};
            res.blue  = {pe[4:0], 3'b000};
            // 16-bit entries carry a transparency bit; 15-bit ones do not
            res.alpha = (cfg_i.palette_depth == PDEPTH_16 &&
                         (pe[15:0] & PAL_ALPHA_BIT) != 16'd0) ? 8'd0 : ALPHA_OPAQUE;
          end
        end else begin
          res.status = ST_BAD_DEPTH;
        end
      end
      default: begin
        res.status = ST_BAD_TYPE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (st_take_o) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
